// ----- hw/rtl/rbsi_pkg.sv -----
// Package: widths, derived constants and normal codes for the ray/box slab intersect block.
`timescale 1ns / 1ps
package rbsi_pkg;

  // Fixed-point format
  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int EXT_W       = COORD_WIDTH - 1;

  // Slab edge minus origin, and its magnitude
  localparam int DIFF_W = COORD_WIDTH + 2;
  localparam int DMAG_W = COORD_WIDTH + 1;

  // Reciprocal magnitude and divider layout
  localparam int RMAG_W = COORD_WIDTH - 1;
  localparam int NSTEP  = 2 * FRAC_BITS;
  localparam int QCMP_W = (NSTEP > RMAG_W) ? NSTEP : RMAG_W;

  // Split multiply of edge distance by reciprocal
  localparam int LO_W   = (DMAG_W + 1) / 2;
  localparam int HI_W   = DMAG_W - LO_W;
  localparam int PROD_W = DMAG_W + RMAG_W;
  localparam int VAL_W  = PROD_W - FRAC_BITS;

  // Pipeline depth: input stage, divider steps, three slab stages, min/max, tmin/tmax, output
  localparam int LAT = NSTEP + 7;

  localparam logic [RMAG_W-1:0] RECIP_CAP = {RMAG_W{1'b1}};

  // Normal codes
  localparam logic [2:0] NORM_NONE = 3'd0;
  localparam logic [2:0] NORM_NX   = 3'd1;
  localparam logic [2:0] NORM_PX   = 3'd2;
  localparam logic [2:0] NORM_NY   = 3'd3;
  localparam logic [2:0] NORM_PY   = 3'd4;

endpackage

// ----- hw/rtl/rbsi_if.sv -----
// Interfaces: ray/box input channel and intersection result channel.
`timescale 1ns / 1ps
interface rbsi_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [rbsi_pkg::COORD_WIDTH-1:0] origin_x;
  logic signed [rbsi_pkg::COORD_WIDTH-1:0] origin_y;
  logic signed [rbsi_pkg::COORD_WIDTH-1:0] dir_x;
  logic signed [rbsi_pkg::COORD_WIDTH-1:0] dir_y;
  logic signed [rbsi_pkg::COORD_WIDTH-1:0] box_x;
  logic signed [rbsi_pkg::COORD_WIDTH-1:0] box_y;
  logic        [rbsi_pkg::EXT_W-1:0]       extent_x;
  logic        [rbsi_pkg::EXT_W-1:0]       extent_y;

  modport source (output valid, origin_x, origin_y, dir_x, dir_y, box_x, box_y,
                  extent_x, extent_y, input ready);
  modport sink   (input valid, origin_x, origin_y, dir_x, dir_y, box_x, box_y,
                  extent_x, extent_y, output ready);
endinterface

interface rbsi_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   hit;
  logic signed [rbsi_pkg::COORD_WIDTH-1:0] distance;
  logic        [2:0]                       normal_code;

  modport source (output valid, hit, distance, normal_code, input ready);
  modport sink   (input valid, hit, distance, normal_code, output ready);
endinterface

// ----- hw/rtl/rbsi_recip.sv -----
// Pipelined reciprocal: 2^(2*FRAC_BITS) / |d|, one quotient bit per stage, saturated.
`timescale 1ns / 1ps
module rbsi_recip (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [rbsi_pkg::COORD_WIDTH-1:0]  dmag_i,
  input  logic                              dneg_i,
  output logic [rbsi_pkg::RMAG_W-1:0]       rmag_o,
  output logic                              rneg_o
);

  localparam int CW = rbsi_pkg::COORD_WIDTH;
  localparam int NS = rbsi_pkg::NSTEP;

  logic [CW-1:0] rem_q  [NS];
  logic [NS-1:0] quo_q  [NS];
  logic [CW-1:0] div_q  [NS];
  logic          small_q[NS];
  logic          neg_q  [NS];

  logic [CW-1:0] rem_in  [NS];
  logic [NS-1:0] quo_in  [NS];
  logic [CW-1:0] div_in  [NS];
  logic          small_in[NS];
  logic          neg_in  [NS];
  logic [CW:0]   rem2    [NS];
  logic          take    [NS];

  // Stage inputs: first stage starts with remainder one (dividend's top bit)
  always_comb begin
    for (int j = 0; j < NS; j++) begin
      if (j == 0) begin
        rem_in[j]   = CW'(1);
        quo_in[j]   = '0;
        div_in[j]   = dmag_i;
        small_in[j] = (dmag_i <= CW'(1));
        neg_in[j]   = dneg_i;
      end else begin
        rem_in[j]   = rem_q[j-1];
        quo_in[j]   = quo_q[j-1];
        div_in[j]   = div_q[j-1];
        small_in[j] = small_q[j-1];
        neg_in[j]   = neg_q[j-1];
      end
      rem2[j] = {rem_in[j], 1'b0};
      take[j] = (rem2[j] >= {1'b0, div_in[j]});
    end
  end

  // One restoring-division step per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NS; j++) begin
        rem_q[j]   <= take[j] ? CW'(rem2[j] - {1'b0, div_in[j]}) : rem2[j][CW-1:0];
        quo_q[j]   <= {quo_in[j][NS-2:0], take[j]};
        div_q[j]   <= div_in[j];
        small_q[j] <= small_in[j];
        neg_q[j]   <= neg_in[j];
      end
    end
  end

  // Saturate to the largest magnitude; a zero direction has a clear sign bit
  always_comb begin
    if (small_q[NS-1] ||
        (rbsi_pkg::QCMP_W'(quo_q[NS-1]) > rbsi_pkg::QCMP_W'(rbsi_pkg::RECIP_CAP))) begin
      rmag_o = rbsi_pkg::RECIP_CAP;
    end else begin
      rmag_o = rbsi_pkg::RMAG_W'(quo_q[NS-1]);
    end
    rneg_o = neg_q[NS-1];
  end

endmodule

// ----- hw/rtl/rbsi_slab.sv -----
// Slab parameter: |diff| * |recip| >> FRAC_BITS, saturated and signed, over three stages.
`timescale 1ns / 1ps
module rbsi_slab (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [rbsi_pkg::DMAG_W-1:0]            dmag_i,
  input  logic                                   dneg_i,
  input  logic [rbsi_pkg::RMAG_W-1:0]            rmag_i,
  input  logic                                   rneg_i,
  output logic signed [rbsi_pkg::COORD_WIDTH-1:0] t_o
);

  localparam int CW  = rbsi_pkg::COORD_WIDTH;
  localparam int LW  = rbsi_pkg::LO_W;
  localparam int HW  = rbsi_pkg::HI_W;
  localparam int RW  = rbsi_pkg::RMAG_W;
  localparam int PW  = rbsi_pkg::PROD_W;
  localparam int VW  = rbsi_pkg::VAL_W;
  localparam logic [VW-1:0] NEG_CAP = VW'(1) << (CW - 1);
  localparam logic [VW-1:0] POS_CAP = NEG_CAP - VW'(1);

  logic [LW+RW-1:0] plo_q;
  logic [HW+RW-1:0] phi_q;
  logic             neg1_q;
  logic [PW-1:0]    sum_q;
  logic             neg2_q;
  logic [CW-1:0]    t_q;

  logic [VW-1:0]    val;
  logic             over;
  logic [CW-1:0]    vcap;

  // Saturate and apply sign
  always_comb begin
    val  = sum_q[PW-1:rbsi_pkg::FRAC_BITS];
    over = neg2_q ? (val > NEG_CAP) : (val > POS_CAP);
    vcap = over ? (neg2_q ? NEG_CAP[CW-1:0] : POS_CAP[CW-1:0]) : val[CW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // partial products
      plo_q  <= dmag_i[LW-1:0] * rmag_i;
      phi_q  <= dmag_i[rbsi_pkg::DMAG_W-1:LW] * rmag_i;
      neg1_q <= dneg_i ^ rneg_i;
      // combine
      sum_q  <= PW'(plo_q) + (PW'(phi_q) << LW);
      neg2_q <= neg1_q;
      // result
      t_q    <= neg2_q ? (CW'(0) - vcap) : vcap;
    end
  end

  assign t_o = t_q;

endmodule

// ----- hw/rtl/ray_box_slab_intersect.sv -----
// Top level: pipelined 2D ray versus axis-aligned box intersection by the slab method.
`timescale 1ns / 1ps
// Takes one ray/box transaction per cycle and returns one result per transaction, in order.
// The pipeline depth is set mainly by the reciprocal divider, which resolves one quotient
// bit per stage; after it come three stages of split multiply and saturation, a min/max
// stage, a tmin/tmax stage and the output register. The whole pipeline advances together;
// it holds only while the output register carries a result that has not been taken.
module ray_box_slab_intersect (
  input  logic      clk_i,
  input  logic      rst_ni,
  rbsi_in_if.sink   in_i,
  rbsi_out_if.source out_o
);

  localparam int CW = rbsi_pkg::COORD_WIDTH;
  localparam int NS = rbsi_pkg::NSTEP;
  localparam int DW = rbsi_pkg::DIFF_W;
  localparam int MW = rbsi_pkg::DMAG_W;
  localparam int L  = rbsi_pkg::LAT;

  logic         en;
  logic [L-1:0] v_q;

  // Stage 0 registers
  logic [CW-1:0]        dxm_q, dym_q;
  logic                 dxn_q, dyn_q;
  logic signed [DW-1:0] diff_q [4];

  // Edge-distance delay line, aligned with the divider
  logic [MW-1:0] dm_q [NS][4];
  logic          ds_q [NS][4];
  logic [MW-1:0] dm_in[4];
  logic          ds_in[4];

  logic [rbsi_pkg::RMAG_W-1:0] rxm, rym;
  logic                        rxn, ryn;
  logic signed [CW-1:0]        t   [4];

  // Min/max and tmin/tmax stages
  logic signed [CW-1:0] lox_q, hix_q, loy_q, hiy_q;
  logic signed [CW-1:0] ta_q [4];
  logic signed [CW-1:0] tmin_q, tmax_q;
  logic signed [CW-1:0] tb_q [4];

  logic                 hit_q;
  logic signed [CW-1:0] dist_q;
  logic [2:0]           code_q;

  logic signed [DW-1:0] ox, oy, bx, by, ex, ey;
  logic                 hit_d;
  logic [2:0]           code_d;

  assign en        = !v_q[L-1] || out_o.ready;
  assign in_i.ready = en;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[L-2:0], in_i.valid};
    end
  end

  // Stage 0: edge minus origin, direction magnitudes
  always_comb begin
    ox = {{2{in_i.origin_x[CW-1]}}, in_i.origin_x};
    oy = {{2{in_i.origin_y[CW-1]}}, in_i.origin_y};
    bx = {{2{in_i.box_x[CW-1]}}, in_i.box_x};
    by = {{2{in_i.box_y[CW-1]}}, in_i.box_y};
    ex = {3'b000, in_i.extent_x};
    ey = {3'b000, in_i.extent_y};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dxn_q     <= in_i.dir_x[CW-1];
      dyn_q     <= in_i.dir_y[CW-1];
      dxm_q     <= in_i.dir_x[CW-1] ? (CW'(0) - in_i.dir_x) : in_i.dir_x;
      dym_q     <= in_i.dir_y[CW-1] ? (CW'(0) - in_i.dir_y) : in_i.dir_y;
      diff_q[0] <= bx - ox;
      diff_q[1] <= bx + ex - ox;
      diff_q[2] <= by + ey - oy;
      diff_q[3] <= by - oy;
    end
  end

  // Magnitude and sign of each edge distance
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ds_in[k] = diff_q[k][DW-1];
      dm_in[k] = diff_q[k][DW-1] ? MW'(DW'(0) - diff_q[k]) : MW'(diff_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < NS; j++) begin
        for (int k = 0; k < 4; k++) begin
          if (j == 0) begin
            dm_q[j][k] <= dm_in[k];
            ds_q[j][k] <= ds_in[k];
          end else begin
            dm_q[j][k] <= dm_q[j-1][k];
            ds_q[j][k] <= ds_q[j-1][k];
          end
        end
      end
    end
  end

  // Reciprocals of the direction components
  rbsi_recip u_recip_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .dmag_i (dxm_q),
    .dneg_i (dxn_q),
    .rmag_o (rxm),
    .rneg_o (rxn)
  );

  rbsi_recip u_recip_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .dmag_i (dym_q),
    .dneg_i (dyn_q),
    .rmag_o (rym),
    .rneg_o (ryn)
  );

  // Four slab parameters: two per axis
  for (genvar k = 0; k < 4; k++) begin : g_slab
    rbsi_slab u_slab (
      .clk_i  (clk_i),
      .en_i   (en),
      .dmag_i (dm_q[NS-1][k]),
      .dneg_i (ds_q[NS-1][k]),
      .rmag_i ((k < 2) ? rxm : rym),
      .rneg_i ((k < 2) ? rxn : ryn),
      .t_o    (t[k])
    );
  end

  // Per-axis min/max, then tmin/tmax
  always_ff @(posedge clk_i) begin
    if (en) begin
      lox_q  <= (t[0] < t[1]) ? t[0] : t[1];
      hix_q  <= (t[0] < t[1]) ? t[1] : t[0];
      loy_q  <= (t[2] < t[3]) ? t[2] : t[3];
      hiy_q  <= (t[2] < t[3]) ? t[3] : t[2];
      ta_q   <= t;
      tmin_q <= (lox_q > loy_q) ? lox_q : loy_q;
      tmax_q <= (hix_q < hiy_q) ? hix_q : hiy_q;
      tb_q   <= ta_q;
    end
  end

  // Hit test and normal selection, first matching slab wins
  always_comb begin
    hit_d  = (tmax_q >= 0) && (tmin_q <= tmax_q);
    code_d = rbsi_pkg::NORM_NONE;
    if (hit_d) begin
      priority if (tmin_q == tb_q[0]) code_d = rbsi_pkg::NORM_NX;
      else if (tmin_q == tb_q[1])     code_d = rbsi_pkg::NORM_PX;
      else if (tmin_q == tb_q[2])     code_d = rbsi_pkg::NORM_NY;
      else if (tmin_q == tb_q[3])     code_d = rbsi_pkg::NORM_PY;
      else                            code_d = rbsi_pkg::NORM_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_d;
      dist_q <= hit_d ? tmin_q : tmax_q;
      code_q <= code_d;
    end
  end

  assign out_o.valid       = v_q[L-1];
  assign out_o.hit         = hit_q;
  assign out_o.distance    = dist_q;
  assign out_o.normal_code = code_q;

  // Checks
  a_hit_has_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.hit) |-> (out_o.normal_code != rbsi_pkg::NORM_NONE))
    else $error("hit without a normal");

  a_miss_no_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.hit) |-> (out_o.normal_code == rbsi_pkg::NORM_NONE))
    else $error("miss with a normal");

  a_stall_holds_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("valid bits moved during a stall");

  a_hit_distance_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[L-2] && hit_d) |-> (tmin_q <= tmax_q))
    else $error("hit with tmin above tmax");

endmodule

// ----- tb/sv/ray_box_slab_intersect_test.sv -----
// Testbench: ray/box slab intersect checked against its own slab-method predictor.
`timescale 1ns / 1ps
module ray_box_slab_intersect_test;

  typedef logic signed [rbsi_pkg::COORD_WIDTH-1:0] coord_t;

  typedef struct {
    coord_t                     ox, oy, dx, dy, bx, by;
    logic [rbsi_pkg::EXT_W-1:0] ex, ey;
  } ray_box_t;

  typedef struct {
    logic       hit;
    coord_t     distance;
    logic [2:0] normal;
  } isect_t;

  localparam longint POS_LIM = (64'sd1 <<< (rbsi_pkg::COORD_WIDTH - 1)) - 1;
  localparam longint NEG_MAG = 64'sd1 <<< (rbsi_pkg::COORD_WIDTH - 1);
  localparam int     ONE     = 1 << rbsi_pkg::FRAC_BITS;
  localparam int     CALM_N  = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rbsi_in_if  in_if ();
  rbsi_out_if out_if ();

  ray_box_slab_intersect dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  ray_box_t pending_rays[$];
  isect_t   expected_isects[$];
  ray_box_t cur_ray;
  int       sent_cnt, recv_cnt, hit_cnt, mismatch_cnt;
  int       src_gap, snk_gap, hold_cnt;
  bit       held_once;
  int       code_seen[5];

  // Reciprocal of one direction component, saturated, sign of d
  function automatic longint recip_of(longint d);
    longint unsigned q;
    if (d == 0) return POS_LIM;
    q = (64'd1 << (2 * rbsi_pkg::FRAC_BITS)) / (d < 0 ? -d : d);
    if (q > POS_LIM) q = POS_LIM;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Slab parameter: diff * recip / 2^FRAC_BITS, magnitude truncated then saturated
  function automatic longint slab_param(longint diff, longint r);
    logic [127:0] da, ra, val, cap;
    bit           neg;
    neg = (diff < 0) != (r < 0);
    da  = diff < 0 ? -diff : diff;
    ra  = r < 0 ? -r : r;
    if (da == 0 || ra == 0) return 0;
    val = (da * ra) >> rbsi_pkg::FRAC_BITS;
    cap = neg ? NEG_MAG : POS_LIM;
    if (val > cap) val = cap;
    return neg ? -longint'(val[63:0]) : longint'(val[63:0]);
  endfunction

  function automatic isect_t predict_isect(ray_box_t r);
    isect_t res;
    longint rx, ry, t1, t2, t3, t4, tmin, tmax;
    rx = recip_of(r.dx);
    ry = recip_of(r.dy);
    t1 = slab_param(longint'(r.bx) - r.ox, rx);
    t2 = slab_param(longint'(r.bx) + longint'({1'b0, r.ex}) - r.ox, rx);
    t3 = slab_param(longint'(r.by) + longint'({1'b0, r.ey}) - r.oy, ry);
    t4 = slab_param(longint'(r.by) - r.oy, ry);
    tmin = (t1 < t2 ? t1 : t2) > (t3 < t4 ? t3 : t4) ? (t1 < t2 ? t1 : t2) : (t3 < t4 ? t3 : t4);
    tmax = (t1 > t2 ? t1 : t2) < (t3 > t4 ? t3 : t4) ? (t1 > t2 ? t1 : t2) : (t3 > t4 ? t3 : t4);
    res.hit = 1'b0;
    res.normal = rbsi_pkg::NORM_NONE;
    res.distance = coord_t'(tmax);
    if (tmax >= 0 && tmin <= tmax) begin
      res.hit = 1'b1;
      res.distance = coord_t'(tmin);
      if (tmin == t1) res.normal = rbsi_pkg::NORM_NX;
      else if (tmin == t2) res.normal = rbsi_pkg::NORM_PX;
      else if (tmin == t3) res.normal = rbsi_pkg::NORM_NY;
      else if (tmin == t4) res.normal = rbsi_pkg::NORM_PY;
    end
    return res;
  endfunction

  task automatic push_ray(int ox, int oy, int dx, int dy, int bx, int by, int ex, int ey);
    ray_box_t r;
    r.ox = ox; r.oy = oy; r.dx = dx; r.dy = dy; r.bx = bx; r.by = by;
    r.ex = ex[rbsi_pkg::EXT_W-1:0]; r.ey = ey[rbsi_pkg::EXT_W-1:0];
    pending_rays.push_back(r);
  endtask

  // Ray aimed near a small box, sometimes axis-parallel, sometimes from inside
  task automatic push_aimed_ray();
    int bx, by, ex, ey, ox, oy, tx, ty, dx, dy;
    bx = $urandom_range(0, 400 * ONE) - 200 * ONE;
    by = $urandom_range(0, 400 * ONE) - 200 * ONE;
    ex = $urandom_range(0, 60 * ONE);
    ey = $urandom_range(0, 60 * ONE);
    if ($urandom_range(0, 5) == 0) begin
      ox = bx + $urandom_range(0, ex);
      oy = by + $urandom_range(0, ey);
    end else begin
      ox = $urandom_range(0, 1000 * ONE) - 500 * ONE;
      oy = $urandom_range(0, 1000 * ONE) - 500 * ONE;
    end
    tx = bx + $urandom_range(0, ex) - ox + $urandom_range(0, 16 * ONE) - 8 * ONE;
    ty = by + $urandom_range(0, ey) - oy + $urandom_range(0, 16 * ONE) - 8 * ONE;
    case ($urandom_range(0, 3))
      0: begin dx = tx >>> 4; dy = ty >>> 4; end
      1: begin dx = tx >>> 10; dy = ty >>> 10; end
      2: begin dx = tx; dy = ty; end
      default: begin dx = $urandom_range(0, 1) ? 0 : tx >>> 6; dy = dx == 0 ? ty >>> 6 : 0; end
    endcase
    push_ray(ox, oy, dx, dy, bx, by, ex, ey);
  endtask

  task automatic push_noise_ray();
    push_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Sender: presents the next ray when the channel is free, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.origin_x <= '0; in_if.origin_y <= '0;
      in_if.dir_x <= '0; in_if.dir_y <= '0;
      in_if.box_x <= '0; in_if.box_y <= '0;
      in_if.extent_x <= '0; in_if.extent_y <= '0;
      src_gap <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        expected_isects.push_back(predict_isect(cur_ray));
        sent_cnt <= sent_cnt + 1;
      end
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_rays.size() > 0) begin
        cur_ray = pending_rays.pop_front();
        in_if.origin_x <= cur_ray.ox; in_if.origin_y <= cur_ray.oy;
        in_if.dir_x <= cur_ray.dx; in_if.dir_y <= cur_ray.dy;
        in_if.box_x <= cur_ray.bx; in_if.box_y <= cur_ray.by;
        in_if.extent_x <= cur_ray.ex; in_if.extent_y <= cur_ray.ey;
        in_if.valid <= 1'b1;
        if (pending_rays.size() > CALM_N && $urandom_range(0, 9) == 0)
          src_gap <= $urandom_range(1, 18);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off so the pipeline fills and stalls its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      held_once <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!held_once && sent_cnt >= 300) begin
      hold_cnt <= 150;
      held_once <= 1'b1;
    end
  end

  // Receiver: checks each result transaction against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    isect_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      snk_gap <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        recv_cnt <= recv_cnt + 1;
        if (expected_isects.size() == 0) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10) $display("ERROR: result with nothing expected");
        end else begin
          want = expected_isects.pop_front();
          if (out_if.hit !== want.hit || out_if.distance !== want.distance ||
              out_if.normal_code !== want.normal) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= 10)
              $display({"ERROR: result %0d: expected hit=%0b dist=%0d code=%0d, ",
                        "got hit=%0b dist=%0d code=%0d"},
                       recv_cnt, want.hit, want.distance, want.normal,
                       out_if.hit, out_if.distance, out_if.normal_code);
          end
          if (want.hit) hit_cnt <= hit_cnt + 1;
          code_seen[want.normal] <= code_seen[want.normal] + 1;
        end
      end
      if (hold_cnt > 0) begin
        out_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (pending_rays.size() > CALM_N && $urandom_range(0, 9) == 0)
          snk_gap <= $urandom_range(1, 18);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int i;
    // each face from outside, misses, zero directions, corners, extremes
    push_ray(-10 * ONE, 2 * ONE, ONE, 0, 0, 0, 4 * ONE, 4 * ONE);
    push_ray(10 * ONE, 2 * ONE, -ONE, 0, 0, 0, 4 * ONE, 4 * ONE);
    push_ray(2 * ONE, 10 * ONE, 0, -ONE, 0, 0, 4 * ONE, 4 * ONE);
    push_ray(2 * ONE, -10 * ONE, 0, ONE, 0, 0, 4 * ONE, 4 * ONE);
    push_ray(10 * ONE, 2 * ONE, ONE, 0, 0, 0, 4 * ONE, 4 * ONE);
    push_ray(2 * ONE, 2 * ONE, 0, 0, 0, 0, 4 * ONE, 4 * ONE);
    push_ray(20 * ONE, 20 * ONE, 0, 0, 0, 0, 4 * ONE, 4 * ONE);
    push_ray(0, 2 * ONE, 0, 0, 0, 0, 4 * ONE, 4 * ONE);
    push_ray(-5 * ONE, -5 * ONE, ONE, ONE, 0, 0, 4 * ONE, 4 * ONE);
    push_ray(2 * ONE, 2 * ONE, ONE, -3 * ONE, 0, 0, 4 * ONE, 4 * ONE);
    push_ray(-10 * ONE, 2 * ONE, 1, 0, 0, 0, 4 * ONE, 4 * ONE);
    push_ray(-10 * ONE, 2 * ONE, 1, -1, 0, 0, 4 * ONE, 4 * ONE);
    push_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 0, 0);
    push_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_ray(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, -1,
             32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    push_ray(0, 0, -1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0);
    push_ray(-1, -1, 0, 0, 0, 0, 0, 0);
    push_ray(0, 0, 0, 0, 0, 0, 0, 0);
    push_ray(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0);
    for (i = 0; i < 1830; i++) begin
      if ($urandom_range(0, 4) == 0) push_noise_ray();
      else push_aimed_ray();
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_rays.size() == 0 && !in_if.valid);
    wait (expected_isects.size() == 0);
    repeat (rbsi_pkg::LAT + 20) @(posedge clk_i);
    if (expected_isects.size() != 0) begin
      mismatch_cnt = mismatch_cnt + expected_isects.size();
      $display("ERROR: %0d results never arrived", expected_isects.size());
    end
    $display("Checked %0d ray/box transactions: %0d hits, %0d mismatches",
             recv_cnt, hit_cnt, mismatch_cnt);
    $display("Normal codes none/-x/+x/-y/+y: %0d/%0d/%0d/%0d/%0d",
             code_seen[0], code_seen[1], code_seen[2], code_seen[3], code_seen[4]);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("ERROR: timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rbsi_pkg.sv
hw/rtl/rbsi_if.sv
hw/rtl/rbsi_recip.sv
hw/rtl/rbsi_slab.sv
hw/rtl/ray_box_slab_intersect.sv
tb/sv/ray_box_slab_intersect_test.sv
